### rtl/tcw_pkg.sv
// ============================================================================
// Text console writer package
// Grid geometry, payload types, operation codes and sequencer states.
// ============================================================================
package tcw_pkg;

  // Grid geometry
  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);

  // Field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;

  // Character codes
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Attribute after reset
  localparam logic [7:0] DEF_ATTR_RESET = 8'd15;

  // Operation codes
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Command transaction
  typedef struct packed {
    logic [1:0]       operation;
    logic [7:0]       character;
    logic [7:0]       attribute;
    logic             use_position;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cmd_t;

  // Response transaction
  typedef struct packed {
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic [7:0]       read_char;
    logic [7:0]       read_attr;
  } rsp_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_DRAIN,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_RESULT
  } state_t;

endpackage

### rtl/tcw_cmd_if.sv
// ============================================================================
// Command channel
// Valid/ready channel that carries one console operation per transaction.
// ============================================================================
interface tcw_cmd_if;
  logic          valid;
  logic          ready;
  tcw_pkg::cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/tcw_rsp_if.sv
// ============================================================================
// Response channel
// Valid/ready channel that carries the cursor and read cell per operation.
// ============================================================================
interface tcw_rsp_if;
  logic          valid;
  logic          ready;
  tcw_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/text_console_writer.sv
// ============================================================================
// Text console writer
// Character/attribute cell grid with cursor, put, clear, read and scroll.
// ============================================================================
// One command at a time. A put that does not scroll runs in the execute state
// and its response goes into the output register as that state ends when the
// register is free; a read passes the execute, read-wait and result states
// before its response is offered. Clear, and a put that scrolls the grid, walk
// every cell through the single-port-write cell memory one cell per cycle.
// After reset the grid is filled with spaces in the reset attribute by the
// same sweep, during which no command is accepted; default attribute writes are
// taken at any time. A finished response sits in an output register, so the
// next command is accepted while the previous response waits to be taken.
module text_console_writer (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  tcw_cmd_if.sink         cmd,
  tcw_rsp_if.source       rsp
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int RW = tcw_pkg::ROW_W;
  localparam int CW = tcw_pkg::COL_W;

  // Cell address from row and column
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    logic [AW-1:0] prod;
    prod = AW'(r) * AW'(tcw_pkg::COLS);
    return prod + AW'(c);
  endfunction

  tcw_pkg::state_t state, state_next;

  // Configuration
  logic [7:0] def_attr;

  // Cursor
  logic [RW-1:0] cursor_row, cursor_row_next;
  logic [CW-1:0] cursor_col, cursor_col_next;

  // Latched command
  logic [1:0]    op_q;
  logic [7:0]    ch_q;
  logic [7:0]    attr_q;
  logic          use_pos_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [7:0]    rd_char_hold, rd_attr_hold;

  // Sweep control
  logic [AW-1:0] sweep_cnt;
  logic          sweep_init, sweep_scroll;
  logic [tcw_pkg::CELL_W-1:0] fill_cell;
  logic          pend_valid, pend_copy;
  logic [AW-1:0] pend_addr;

  // Cell memory
  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [tcw_pkg::CELL_W-1:0] wr_data;

  // Output register
  logic          rsp_valid;
  tcw_pkg::rsp_t rsp_data;

  // Sequencer controls
  logic          accept;
  logic          load_out;
  logic          start_clear, start_scroll;
  logic          exec_we;
  logic [AW-1:0] exec_addr;
  logic [tcw_pkg::CELL_W-1:0] exec_data;
  logic          out_free;
  logic          sweep_copy;

  // Scratch values for the put path
  logic [RW-1:0] pos_row;
  logic [CW-1:0] pos_col;
  logic [7:0]    eff_attr;
  logic          adv_row;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == tcw_pkg::ST_IDLE);
  assign out_free  = !rsp_valid || rsp.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign pos_row  = use_pos_q ? row_q : cursor_row;
  assign pos_col  = use_pos_q ? col_q : cursor_col;
  assign eff_attr = (attr_q == 8'd0) ? def_attr : attr_q;
  assign sweep_copy = sweep_scroll &&
                      (sweep_cnt < AW'(tcw_pkg::CELLS - tcw_pkg::COLS));

  // Next state and sequencer outputs
  always_comb begin
    state_next      = state;
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    load_out        = 1'b0;
    start_clear     = 1'b0;
    start_scroll    = 1'b0;
    exec_we         = 1'b0;
    exec_addr       = cell_addr(pos_row, pos_col);
    exec_data       = {eff_attr, ch_q};
    rd_addr         = cell_addr(row_q, col_q);
    adv_row         = 1'b0;

    unique case (state)
      tcw_pkg::ST_SWEEP: begin
        rd_addr = sweep_cnt + AW'(tcw_pkg::COLS);
        if (sweep_cnt == AW'(tcw_pkg::CELLS - 1)) begin
          state_next = tcw_pkg::ST_DRAIN;
        end
      end

      tcw_pkg::ST_DRAIN: begin
        state_next = sweep_init ? tcw_pkg::ST_IDLE : tcw_pkg::ST_RESULT;
      end

      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = tcw_pkg::ST_EXEC;
        end
      end

      tcw_pkg::ST_EXEC: begin
        state_next = tcw_pkg::ST_RESULT;
        case (op_q)
          tcw_pkg::OP_PUT: begin
            if (ch_q == tcw_pkg::CH_NEWLINE) begin
              adv_row = 1'b1;
            end else if (ch_q == tcw_pkg::CH_BACKSPACE) begin
              if (use_pos_q && (col_q != '0)) begin
                exec_we         = 1'b1;
                exec_addr       = cell_addr(row_q, col_q - CW'(1));
                exec_data       = {eff_attr, tcw_pkg::CH_SPACE};
                cursor_row_next = row_q;
                cursor_col_next = col_q - CW'(1);
              end else begin
                cursor_row_next = pos_row;
                cursor_col_next = pos_col;
              end
            end else begin
              exec_we = 1'b1;
              if (pos_col == CW'(tcw_pkg::COLS - 1)) begin
                adv_row = 1'b1;
              end else begin
                cursor_row_next = pos_row;
                cursor_col_next = pos_col + CW'(1);
              end
            end
            // Row advance, scrolling off the bottom
            if (adv_row) begin
              cursor_col_next = '0;
              if (pos_row == RW'(tcw_pkg::ROWS - 1)) begin
                cursor_row_next = RW'(tcw_pkg::ROWS - 1);
                start_scroll    = 1'b1;
                state_next      = tcw_pkg::ST_SWEEP;
              end else begin
                cursor_row_next = pos_row + RW'(1);
              end
            end
          end
          tcw_pkg::OP_CLEAR: begin
            cursor_row_next = '0;
            cursor_col_next = '0;
            start_clear     = 1'b1;
            state_next      = tcw_pkg::ST_SWEEP;
          end
          tcw_pkg::OP_READ: begin
            state_next = tcw_pkg::ST_RDWAIT;
          end
          default: begin
            state_next = tcw_pkg::ST_RESULT;
          end
        endcase
        // Fast path: offer the response right away when the slot is free
        if ((state_next == tcw_pkg::ST_RESULT) && out_free) begin
          load_out   = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end
      end

      tcw_pkg::ST_RDWAIT: begin
        state_next = tcw_pkg::ST_RESULT;
      end

      tcw_pkg::ST_RESULT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory write port: sweep stage has the port while it runs
  always_comb begin
    if (pend_valid) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr;
      wr_data = pend_copy ? rdata : fill_cell;
    end else begin
      wr_en   = exec_we;
      wr_addr = exec_addr;
      wr_data = exec_data;
    end
  end

  // Cell memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Default attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      def_attr <= tcw_pkg::DEF_ATTR_RESET;
    end else if (cfg_we) begin
      def_attr <= cfg_wdata;
    end
  end

  // Cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= '0;
      cursor_col <= '0;
    end else begin
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
    end
  end

  // Command latch with position clamping
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= cmd.data.operation;
      ch_q      <= cmd.data.character;
      attr_q    <= cmd.data.attribute;
      use_pos_q <= cmd.data.use_position;
      row_q     <= (cmd.data.row >= RW'(tcw_pkg::ROWS)) ?
                   RW'(tcw_pkg::ROWS - 1) : cmd.data.row;
      col_q     <= (cmd.data.col >= CW'(tcw_pkg::COLS)) ?
                   CW'(tcw_pkg::COLS - 1) : cmd.data.col;
    end
  end

  // Read data hold: zero unless a read fetched a cell
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_char_hold <= '0;
      rd_attr_hold <= '0;
    end else if (state == tcw_pkg::ST_RDWAIT) begin
      rd_char_hold <= rdata[7:0];
      rd_attr_hold <= rdata[15:8];
    end
  end

  // Sweep counter and setup
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt    <= '0;
      sweep_init   <= 1'b1;
      sweep_scroll <= 1'b0;
      fill_cell    <= {tcw_pkg::DEF_ATTR_RESET, tcw_pkg::CH_SPACE};
    end else if (start_clear) begin
      sweep_cnt    <= '0;
      sweep_init   <= 1'b0;
      sweep_scroll <= 1'b0;
      fill_cell    <= {def_attr, tcw_pkg::CH_SPACE};
    end else if (start_scroll) begin
      sweep_cnt    <= '0;
      sweep_init   <= 1'b0;
      sweep_scroll <= 1'b1;
      fill_cell    <= '0;
    end else if (state == tcw_pkg::ST_SWEEP) begin
      sweep_cnt <= sweep_cnt + AW'(1);
    end
  end

  // Sweep write stage, in the cycle after the read of the source cell
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= (state == tcw_pkg::ST_SWEEP);
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= sweep_cnt;
    pend_copy <= sweep_copy;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp_data.cursor_row <= cursor_row_next;
      rsp_data.cursor_col <= cursor_col_next;
      rsp_data.read_char  <= rd_char_hold;
      rsp_data.read_attr  <= rd_attr_hold;
    end
  end

  // Assertions
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cursor_row < RW'(tcw_pkg::ROWS)) && (cursor_col < CW'(tcw_pkg::COLS)))
    else $error("cursor outside the grid");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_addr < AW'(tcw_pkg::CELLS)))
    else $error("cell write outside the grid");

  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("response overwritten before it was taken");

  a_port_owner: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !exec_we)
    else $error("sweep and command both drive the write port");

  a_copy_src: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::ST_SWEEP && sweep_copy) |-> (rd_addr < AW'(tcw_pkg::CELLS)))
    else $error("scroll source outside the grid");

endmodule

### bench/tb_text_console_writer.sv
`timescale 1ns / 100ps
// ============================================================================
// Text console writer testbench
// Drives console operations over the command channel with random gaps and
// response stalls. A shadow copy of the cell grid, cursor and default
// attribute predicts every response, and each response is checked field by
// field. A directed opening covers the corner cases: clamping, backspace,
// scrolling, clear and the spare opcode. Five random phases follow, each
// under its own default attribute.
// ============================================================================
module tb_text_console_writer;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int SLOW_OP_CAP      = 150;        // clears plus scrolls
  localparam int ITEMS_PER_PHASE  = 390;
  localparam int CYCLE_LIMIT      = 2_000_000;

  // Shadow of the console: cell grid, cursor, default attribute and the
  // responses still owed by the block.
  class console_shadow;
    bit [15:0]     cells [tcw_pkg::CELLS];
    int unsigned   cursor;
    bit [7:0]      dflt_attr;
    tcw_pkg::rsp_t owed [$];
    int            bad;

    function void blank();
      foreach (cells[i]) cells[i] = {dflt_attr, tcw_pkg::CH_SPACE};
      cursor = 0;
    endfunction

    function void power_up();
      dflt_attr = tcw_pkg::DEF_ATTR_RESET;
      blank();
      owed.delete();
      bad = 0;
    endfunction

    // Update the grid for one accepted command and queue its response
    function void apply(tcw_pkg::cmd_t c);
      int unsigned   r, col, pos;
      bit [7:0]      at;
      tcw_pkg::rsp_t e;
      r   = (c.row > tcw_pkg::ROWS - 1) ? tcw_pkg::ROWS - 1 : c.row;
      col = (c.col > tcw_pkg::COLS - 1) ? tcw_pkg::COLS - 1 : c.col;
      e   = '0;
      if (c.operation == tcw_pkg::OP_PUT) begin
        at  = (c.attribute == 8'd0) ? dflt_attr : c.attribute;
        pos = c.use_position ? r * tcw_pkg::COLS + col : cursor;
        if (c.character == tcw_pkg::CH_NEWLINE) begin
          pos = (pos / tcw_pkg::COLS + 1) * tcw_pkg::COLS;
        end else if (c.character == tcw_pkg::CH_BACKSPACE) begin
          // only a positioned backspace off column 0 blanks a cell
          if (c.use_position && col > 0) begin
            pos = r * tcw_pkg::COLS + col - 1;
            cells[pos] = {at, tcw_pkg::CH_SPACE};
          end
        end else begin
          cells[pos] = {at, c.character};
          pos++;
        end
        // ran off the end: shift up one row, bottom row becomes all zero
        if (pos >= tcw_pkg::CELLS) begin
          for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLS; i++)
            cells[i] = cells[i + tcw_pkg::COLS];
          for (int i = tcw_pkg::CELLS - tcw_pkg::COLS; i < tcw_pkg::CELLS; i++)
            cells[i] = '0;
          pos -= tcw_pkg::COLS;
        end
        cursor = pos;
      end else if (c.operation == tcw_pkg::OP_CLEAR) begin
        blank();
      end else if (c.operation == tcw_pkg::OP_READ) begin
        e.read_char = cells[r * tcw_pkg::COLS + col][7:0];
        e.read_attr = cells[r * tcw_pkg::COLS + col][15:8];
      end
      e.cursor_row = 5'(cursor / tcw_pkg::COLS);
      e.cursor_col = 7'(cursor % tcw_pkg::COLS);
      owed.push_back(e);
    endfunction

    // Compare one response against the oldest owed one
    function void check(tcw_pkg::rsp_t got);
      tcw_pkg::rsp_t e;
      if (owed.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("unexpected response: row %0d col %0d char %02h attr %02h",
                   got.cursor_row, got.cursor_col, got.read_char, got.read_attr);
        return;
      end
      e = owed.pop_front();
      if (got.cursor_row !== e.cursor_row || got.cursor_col !== e.cursor_col ||
          got.read_char !== e.read_char || got.read_attr !== e.read_attr) begin
        bad++;
        if (bad <= 10)
          $display("mismatch: exp %0d/%0d %02h %02h, got %0d/%0d %02h %02h",
                   e.cursor_row, e.cursor_col, e.read_char, e.read_attr,
                   got.cursor_row, got.cursor_col, got.read_char, got.read_attr);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_wdata;
  logic calm;
  int   slow_ops = 0;
  int   cycles = 0;

  console_shadow shadow = new;

  tcw_cmd_if cmd_ch ();
  tcw_rsp_if rsp_ch ();

  text_console_writer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  always #6 clk = ~clk;

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic tcw_pkg::cmd_t mk(logic [1:0] op, logic [7:0] ch, logic [7:0] at,
                                       logic use_pos, logic [4:0] r, logic [6:0] col);
    tcw_pkg::cmd_t c;
    c.operation    = op;
    c.character    = ch;
    c.attribute    = at;
    c.use_position = use_pos;
    c.row          = r;
    c.col          = col;
    return c;
  endfunction

  function automatic logic [7:0] pick_char();
    int k;
    k = $urandom_range(0, 99);
    if (k < 8)  return tcw_pkg::CH_NEWLINE;
    if (k < 11) return tcw_pkg::CH_BACKSPACE;
    if (k < 20) return 8'($urandom);
    return 8'($urandom_range(32, 126));
  endfunction

  // Random command; text at the cursor dominates. Clears and scrolls are
  // rationed, past the ration they turn into puts in the upper rows.
  function automatic tcw_pkg::cmd_t random_cmd();
    tcw_pkg::cmd_t c;
    int            k;
    int unsigned   r, col, pos;
    bit            slow;
    k = $urandom_range(0, 99);
    c = mk(tcw_pkg::OP_PUT, pick_char(),
           ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom), 1'b0,
           5'($urandom_range(0, tcw_pkg::ROWS - 1)),
           7'($urandom_range(0, tcw_pkg::COLS - 1)));
    if ($urandom_range(0, 99) < 15) begin
      c.row = 5'($urandom);
      c.col = 7'($urandom);
    end
    if (k >= 45 && k < 70) begin
      c.use_position = 1'b1;
      if ($urandom_range(0, 99) < 15) c.character = tcw_pkg::CH_BACKSPACE;
    end else if (k >= 70 && k < 96) begin
      c.operation    = tcw_pkg::OP_READ;
      c.use_position = 1'($urandom);
    end else if (k >= 96 && k < 98) begin
      c.operation = tcw_pkg::OP_CLEAR;
    end else if (k >= 98) begin
      c = tcw_pkg::cmd_t'({OP_SPARE, 29'($urandom)});
    end

    r    = (c.row > tcw_pkg::ROWS - 1) ? tcw_pkg::ROWS - 1 : c.row;
    col  = (c.col > tcw_pkg::COLS - 1) ? tcw_pkg::COLS - 1 : c.col;
    pos  = c.use_position ? r * tcw_pkg::COLS + col : shadow.cursor;
    slow = (c.operation == tcw_pkg::OP_CLEAR) ||
           (c.operation == tcw_pkg::OP_PUT &&
            ((c.character == tcw_pkg::CH_NEWLINE &&
              pos / tcw_pkg::COLS == tcw_pkg::ROWS - 1) ||
             (c.character != tcw_pkg::CH_NEWLINE &&
              c.character != tcw_pkg::CH_BACKSPACE &&
              pos == tcw_pkg::CELLS - 1)));
    if (slow) begin
      if (slow_ops >= SLOW_OP_CAP) begin
        c.operation    = tcw_pkg::OP_PUT;
        c.use_position = 1'b1;
        c.row          = 5'($urandom_range(0, tcw_pkg::ROWS - 2));
      end else begin
        slow_ops++;
      end
    end
    return c;
  endfunction

  // Offer one transaction and wait for it to be taken; entered and left at
  // a falling edge.
  task automatic send(input tcw_pkg::cmd_t c);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    shadow.apply(c);
    @(negedge clk);
  endtask

  // Withdraw the command offer and wait until every response is in
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (shadow.owed.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_default(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    shadow.dflt_attr = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    // reset cell, then a clamped read
    send(mk(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 5'd0, 7'd0));
    send(mk(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b1, 5'd31, 7'd127));
    // default attribute, then character zero
    send(mk(tcw_pkg::OP_PUT, "A", 8'd0, 1'b0, 5'd0, 7'd0));
    send(mk(tcw_pkg::OP_PUT, 8'hFF, 8'hFF, 1'b0, 5'd0, 7'd0));
    send(mk(tcw_pkg::OP_PUT, 8'h00, 8'h01, 1'b0, 5'd0, 7'd0));
    send(mk(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 8'd0, 1'b0, 5'd0, 7'd0));
    // backspace without position
    send(mk(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 8'h22, 1'b0, 5'd0, 7'd0));
    send(mk(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 5'd0, 7'd2));
    // last cell, scroll; then the scrolled-in row
    send(mk(tcw_pkg::OP_PUT, "B", 8'h44, 1'b1, 5'd31, 7'd127));
    send(mk(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 5'd23, 7'd79));
    send(mk(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 5'd24, 7'd5));
    // backspace at column 0, then one that blanks the left cell
    send(mk(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 8'd0, 1'b1, 5'd3, 7'd0));
    send(mk(tcw_pkg::OP_PUT, "C", 8'h80, 1'b1, 5'd3, 7'd10));
    send(mk(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 8'd0, 1'b1, 5'd3, 7'd11));
    send(mk(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 5'd3, 7'd10));
    // newline scroll
    send(mk(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 8'd0, 1'b1, 5'd24, 7'd40));
    send(mk(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 5'd2, 7'd10));
    // spare opcode
    send(mk(OP_SPARE, 8'h5A, 8'hA5, 1'b1, 5'd12, 7'd33));
    // column clamp
    send(mk(tcw_pkg::OP_PUT, "E", 8'h7F, 1'b1, 5'd5, 7'd100));
    send(mk(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 5'd5, 7'd79));
    send(mk(tcw_pkg::OP_CLEAR, 8'd0, 8'd0, 1'b0, 5'd0, 7'd0));
    send(mk(tcw_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 5'd10, 7'd10));
    send(mk(tcw_pkg::OP_PUT, "D", 8'd0, 1'b0, 5'd0, 7'd0));
  endtask

  // Response side: random stalls unless in a calm phase
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Response check and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      shadow.check(rsp_ch.data);
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Main sequence
  initial begin
    logic [7:0] phase_attr [5];
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = 8'd0;
    calm         = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    shadow.power_up();
    phase_attr = '{8'hFF, 8'h00, 8'($urandom), 8'h01, 8'($urandom)};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_default(phase_attr[p]);
      calm = (p == 2);
      repeat (ITEMS_PER_PHASE) send(random_cmd());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (shadow.bad == 0 && shadow.owed.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tcw_pkg.sv
rtl/tcw_cmd_if.sv
rtl/tcw_rsp_if.sv
rtl/text_console_writer.sv
bench/tb_text_console_writer.sv
